// ===== src/bmpp_pkg.sv =====
// Package for the bicycle path point predictor.
// Holds fixed-point widths, angle constants, register indexes and helper functions.
// Used by every module in src.
package bmpp_pkg;

	localparam int POS_W  = 20;
	localparam int ANG_W  = 16;
	localparam int TRIG_W = 18;
	localparam int CZ_W   = 20;
	localparam int DS_W   = 21;
	localparam int HEAD_W = 18;
	localparam int DPSI_W = 17;
	localparam int ACC_W  = 46;
	localparam int DVN_W  = 54;
	localparam int DVD_W  = 50;
	localparam int STEP_W = 5;

	localparam int MAX_STEPS_DEF = 31;

	localparam logic signed [ANG_W-1:0] ANG_LIMIT   = 16'sd19661;
	localparam logic signed [POS_W-1:0] PI_Q14      = 20'sd51472;
	localparam logic signed [POS_W-1:0] TWO_PI_Q14  = 20'sd102944;
	localparam logic signed [CZ_W-1:0]  PI_Q16      = 20'sd205887;
	localparam logic signed [CZ_W-1:0]  HALF_PI_Q16 = 20'sd102944;
	localparam logic signed [CZ_W-1:0]  CORDIC_K    = 20'sd39797;
	localparam logic signed [CZ_W-1:0]  ONE_Q16     = 20'sd65536;

	localparam logic [15:0] WHEELBASE_RST   = 16'd2867;
	localparam logic [19:0] PATH_LENGTH_RST = 20'd20480;
	localparam logic [4:0]  STEP_COUNT_RST  = 5'd20;
	localparam logic [15:0] HALF_WIDTH_RST  = 16'd1024;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_WHEELBASE   = 3'd0;
	localparam reg_idx_t REG_PATH_LENGTH = 3'd1;
	localparam reg_idx_t REG_STEP_COUNT  = 3'd2;
	localparam reg_idx_t REG_HALF_WIDTH  = 3'd3;
	localparam reg_idx_t REG_OUTPUT_MODE = 3'd4;

	localparam logic [1:0] SIDE_CENTER = 2'd0;
	localparam logic [1:0] SIDE_LEFT   = 2'd1;
	localparam logic [1:0] SIDE_RIGHT  = 2'd2;

	function automatic logic signed [CZ_W-1:0] atan_q16(input logic [3:0] i);
		logic signed [CZ_W-1:0] r;
		unique case (i)
			4'd0: r = 20'sd51472;
			4'd1: r = 20'sd30386;
			4'd2: r = 20'sd16055;
			4'd3: r = 20'sd8150;
			4'd4: r = 20'sd4091;
			4'd5: r = 20'sd2047;
			4'd6: r = 20'sd1024;
			4'd7: r = 20'sd512;
			4'd8: r = 20'sd256;
			4'd9: r = 20'sd128;
			4'd10: r = 20'sd64;
			4'd11: r = 20'sd32;
			4'd12: r = 20'sd16;
			4'd13: r = 20'sd8;
			4'd14: r = 20'sd4;
			4'd15: r = 20'sd2;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Rounds a Q.26 position to Q10.10 and saturates it to the field range.
	function automatic logic signed [POS_W-1:0] to_pos(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		r = (v + ACC_W'(32768)) >>> 16;
		if (r > ACC_W'(524287)) begin
			return 20'sd524287;
		end else if (r < -ACC_W'(524288)) begin
			return -20'sd524288;
		end
		return r[POS_W-1:0];
	endfunction

endpackage

// ===== src/bicycle_model_path_points_top.sv =====
// Kinematic bicycle path predictor: one steering angle in, a stream of path points out.
// Before its first point each item uses three runs of the shared divider (step length,
// then the heading increment reduced to one turn over two divisions) and one CORDIC run.
// Each Euler step then waits for the CORDIC run of the new heading, for the right
// edge point after the left one when edge points are output, and for any output stall.
// Depends on bmpp_pkg, bmpp_div and bmpp_cordic.
module bicycle_model_path_points_top import bmpp_pkg::*; #(
	parameter int MAX_STEPS = MAX_STEPS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [4:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [ANG_W-1:0] steer_angle,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [POS_W-1:0] pos_x,
	output logic signed [POS_W-1:0] pos_y,
	output logic [1:0]              point_side,
	output logic [STEP_W-1:0]       step_index,
	output logic                    last
);

	typedef enum logic [11:0] {
		S_IDLE = 12'b000000000001,
		S_DS   = 12'b000000000010,
		S_SCA  = 12'b000000000100,
		S_MUL  = 12'b000000001000,
		S_MAG  = 12'b000000010000,
		S_DMAG = 12'b000000100000,
		S_DMOD = 12'b000001000000,
		S_OFS  = 12'b000010000000,
		S_EMIT = 12'b000100000000,
		S_MOVE = 12'b001000000000,
		S_ACC  = 12'b010000000000,
		S_SCH  = 12'b100000000000
	} state_t;

	state_t state_q;

	logic [15:0] wheelbase_q, half_width_q;
	logic [19:0] path_length_q;
	logic [4:0]  step_count_q;
	logic        output_mode_q;
	reg_idx_t    widx;

	assign pready = 1'b1;
	assign widx   = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheelbase_q   <= WHEELBASE_RST;
			path_length_q <= PATH_LENGTH_RST;
			step_count_q  <= STEP_COUNT_RST;
			half_width_q  <= HALF_WIDTH_RST;
			output_mode_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (widx)
				REG_WHEELBASE:   wheelbase_q   <= pwdata[15:0];
				REG_PATH_LENGTH: path_length_q <= pwdata[19:0];
				REG_STEP_COUNT:  step_count_q  <= pwdata[4:0];
				REG_HALF_WIDTH:  half_width_q  <= pwdata[15:0];
				REG_OUTPUT_MODE: output_mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (widx)
			REG_WHEELBASE:   prdata = {16'd0, wheelbase_q};
			REG_PATH_LENGTH: prdata = {12'd0, path_length_q};
			REG_STEP_COUNT:  prdata = {27'd0, step_count_q};
			REG_HALF_WIDTH:  prdata = {16'd0, half_width_q};
			REG_OUTPUT_MODE: prdata = {31'd0, output_mode_q};
			default:         prdata = '0;
		endcase
	end

	// Datapath registers.
	logic signed [ANG_W-1:0]  ang_q;
	logic [STEP_W-1:0]        n_q, i_q;
	logic [DS_W-1:0]          ds_q;
	logic signed [TRIG_W-1:0] sa_q, ca_q, s_q, c_q;
	logic signed [39:0]       prod_q;
	logic [32:0]              den_q;
	logic                     nneg_q;
	logic [DPSI_W-1:0]        dpsi_q;
	logic signed [HEAD_W-1:0] head_q;
	logic signed [ACC_W-1:0]  x_q, y_q;
	logic signed [34:0]       hwc_q, hws_q;
	logic signed [39:0]       mc_q, ms_q;
	logic                     sel_q;

	// Shared units.
	logic                   div_start, div_busy, div_done;
	logic [DVN_W-1:0]       div_n, div_quo;
	logic [DVD_W-1:0]       div_d, div_rem;
	logic                   cor_start, cor_busy, cor_done;
	logic signed [CZ_W-1:0] cor_ang;
	logic signed [TRIG_W-1:0] cor_s, cor_c;

	bmpp_div #(.DVN(DVN_W), .DVD(DVD_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_n), .divisor(div_d),
		.busy(div_busy), .done(div_done), .quotient(div_quo), .remainder(div_rem)
	);

	bmpp_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cor_start), .angle(cor_ang),
		.busy(cor_busy), .done(cor_done), .sin_v(cor_s), .cos_v(cor_c)
	);

	logic [STEP_W-1:0]        n_c;
	logic signed [ANG_W-1:0]  ang_c;
	logic [39:0]              num_abs;
	logic signed [HEAD_W:0]   head_sum;
	logic signed [HEAD_W-1:0] head_nx;
	logic                     accept_in, out_free, fin;

	assign accept_in = in_valid && in_ready;
	assign out_free  = !out_valid || out_ready;
	assign fin       = (i_q == n_q);
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		if (step_count_q == '0) begin
			n_c = STEP_W'(1);
		end else if (step_count_q > STEP_W'(MAX_STEPS)) begin
			n_c = STEP_W'(MAX_STEPS);
		end else begin
			n_c = step_count_q;
		end
		if (steer_angle > ANG_LIMIT) begin
			ang_c = ANG_LIMIT;
		end else if (steer_angle < -ANG_LIMIT) begin
			ang_c = -ANG_LIMIT;
		end else begin
			ang_c = steer_angle;
		end
		num_abs  = prod_q[39] ? 40'(-prod_q) : 40'(prod_q);
		head_sum = {head_q[HEAD_W-1], head_q} + $signed({2'b00, dpsi_q});
		if (head_sum >= (HEAD_W+1)'(PI_Q14)) begin
			head_sum = head_sum - (HEAD_W+1)'(TWO_PI_Q14);
		end
		head_nx = head_sum[HEAD_W-1:0];
	end

	// The heading increment modulo a full turn is the quotient of the remainder of the
	// rounded numerator over (denominator times a full turn), divided by the denominator.
	always_comb begin
		div_start = 1'b0;
		div_n     = '0;
		div_d     = '0;
		unique case (state_q)
			S_IDLE: begin
				div_start = accept_in;
				div_n     = DVN_W'({1'b0, path_length_q} + {16'd0, n_c[STEP_W-1:1]});
				div_d     = DVD_W'(n_c);
			end
			S_MAG: begin
				div_start = 1'b1;
				div_n     = DVN_W'({num_abs, 14'd0}) + DVN_W'(den_q[32:1]);
				div_d     = DVD_W'(den_q) * DVD_W'(TWO_PI_Q14);
			end
			S_DMAG: begin
				div_start = div_done;
				div_n     = DVN_W'(div_rem);
				div_d     = DVD_W'(den_q);
			end
			default: ;
		endcase
	end

	assign cor_start = (state_q == S_DS && div_done) || (state_q == S_ACC);
	assign cor_ang   = (state_q == S_ACC) ? {head_nx, 2'b00} : {{2{ang_q[ANG_W-1]}}, ang_q, 2'b00};

	logic [DPSI_W-1:0] rmod;
	assign rmod = div_quo[DPSI_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (accept_in) state_q <= S_DS;
				S_DS:   if (div_done) state_q <= S_SCA;
				S_SCA:  if (cor_done) state_q <= S_MUL;
				S_MUL:  state_q <= S_MAG;
				S_MAG:  state_q <= S_DMAG;
				S_DMAG: if (div_done) state_q <= S_DMOD;
				S_DMOD: if (div_done) state_q <= S_OFS;
				S_OFS:  state_q <= S_EMIT;
				S_EMIT: begin
					if (out_free) begin
						out_valid <= 1'b1;
						if (!output_mode_q || sel_q) begin
							state_q <= fin ? S_IDLE : S_MOVE;
						end
					end
				end
				S_MOVE: state_q <= S_ACC;
				S_ACC:  state_q <= S_SCH;
				S_SCH:  if (cor_done) state_q <= S_OFS;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				ang_q <= ang_c;
				n_q   <= n_c;
			end
			S_DS: if (div_done) ds_q <= div_quo[DS_W-1:0];
			S_SCA: begin
				sa_q <= cor_s;
				ca_q <= cor_c;
			end
			S_MUL: begin
				prod_q <= sa_q * $signed({1'b0, ds_q});
				den_q  <= 33'((ca_q > 0) ? 17'(ca_q) : 17'd1)
					* 33'((wheelbase_q != '0) ? wheelbase_q : 16'd1);
			end
			S_MAG: nneg_q <= prod_q[39];
			S_DMOD: begin
				if (div_done) begin
					dpsi_q <= (nneg_q && rmod != '0) ? DPSI_W'(TWO_PI_Q14) - rmod : rmod;
					head_q <= '0;
					x_q    <= '0;
					y_q    <= '0;
					s_q    <= '0;
					c_q    <= TRIG_W'(ONE_Q16);
					i_q    <= '0;
					sel_q  <= 1'b0;
				end
			end
			S_OFS: begin
				hwc_q <= $signed({1'b0, half_width_q}) * c_q;
				hws_q <= $signed({1'b0, half_width_q}) * s_q;
			end
			S_EMIT: begin
				if (out_free) begin
					step_index <= i_q;
					if (!output_mode_q) begin
						pos_x      <= to_pos(x_q);
						pos_y      <= to_pos(y_q);
						point_side <= SIDE_CENTER;
						last       <= fin;
					end else if (!sel_q) begin
						pos_x      <= to_pos(x_q - ACC_W'(hwc_q));
						pos_y      <= to_pos(y_q + ACC_W'(hws_q));
						point_side <= SIDE_LEFT;
						last       <= 1'b0;
						sel_q      <= 1'b1;
					end else begin
						pos_x      <= to_pos(x_q + ACC_W'(hwc_q));
						pos_y      <= to_pos(y_q - ACC_W'(hws_q));
						point_side <= SIDE_RIGHT;
						last       <= fin;
						sel_q      <= 1'b0;
					end
				end
			end
			S_MOVE: begin
				mc_q <= c_q * $signed({1'b0, ds_q});
				ms_q <= s_q * $signed({1'b0, ds_q});
			end
			S_ACC: begin
				y_q    <= y_q + ACC_W'(mc_q);
				x_q    <= x_q + ACC_W'(ms_q);
				head_q <= head_nx;
				i_q    <= i_q + 1'b1;
			end
			S_SCH: begin
				if (cor_done) begin
					s_q <= cor_s;
					c_q <= cor_c;
				end
			end
			default: ;
		endcase
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept_in |=> !in_ready) else $error("input taken while a path is in progress");
	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy) else $error("divider restarted while busy");
	a_cordic_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		cor_start |-> !cor_busy) else $error("CORDIC restarted while busy");
	a_side_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (point_side == SIDE_CENTER || point_side == SIDE_LEFT
			|| point_side == SIDE_RIGHT)) else $error("bad point side on a transfer");

endmodule

// ===== src/bmpp_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on bmpp_pkg for its default widths.
module bmpp_div import bmpp_pkg::*; #(
	parameter int DVN = DVN_W,
	parameter int DVD = DVD_W
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [DVN-1:0] dividend,
	input  logic [DVD-1:0] divisor,
	output logic           busy,
	output logic           done,
	output logic [DVN-1:0] quotient,
	output logic [DVD-1:0] remainder
);

	localparam int CNT_W = $clog2(DVN);

	logic             busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVN-1:0]   quo_q;
	logic [DVD-1:0]   rem_q, div_q;
	logic [DVD:0]     trial, diff;
	logic             ge;

	assign trial = {rem_q, quo_q[DVN-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(DVN - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVD-1:0] : trial[DVD-1:0];
			quo_q <= {quo_q[DVN-2:0], ge};
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== src/bmpp_cordic.sv =====
// Sixteen-iteration rotation CORDIC giving sine and cosine in Q.16.
// Depends on bmpp_pkg for the arctangent table and angle constants.
module bmpp_cordic import bmpp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [CZ_W-1:0]   angle,
	output logic                     busy,
	output logic                     done,
	output logic signed [TRIG_W-1:0] sin_v,
	output logic signed [TRIG_W-1:0] cos_v
);

	logic                   busy_q, done_q, neg_q;
	logic [3:0]             cnt_q;
	logic signed [CZ_W-1:0] x_q, y_q, z_q, dx, dy, za;
	logic signed [CZ_W-1:0] fold;
	logic                   fneg;

	always_comb begin
		fold = angle;
		fneg = 1'b0;
		if (angle > HALF_PI_Q16) begin
			fold = angle - PI_Q16;
			fneg = 1'b1;
		end else if (angle < -HALF_PI_Q16) begin
			fold = angle + PI_Q16;
			fneg = 1'b1;
		end
	end

	assign dx = y_q >>> cnt_q;
	assign dy = x_q >>> cnt_q;
	assign za = atan_q16(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			cnt_q  <= '0;
			busy_q <= (angle != '0);
			done_q <= (angle == '0);
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == 4'd15) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			if (angle == '0) begin
				x_q   <= ONE_Q16;
				y_q   <= '0;
				z_q   <= '0;
				neg_q <= 1'b0;
			end else begin
				x_q   <= CORDIC_K;
				y_q   <= '0;
				z_q   <= fold;
				neg_q <= fneg;
			end
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - za;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + za;
			end
		end
	end

	logic signed [CZ_W-1:0] s_full, c_full;
	assign s_full = neg_q ? -y_q : y_q;
	assign c_full = neg_q ? -x_q : x_q;
	assign sin_v  = s_full[TRIG_W-1:0];
	assign cos_v  = c_full[TRIG_W-1:0];
	assign busy   = busy_q;
	assign done   = done_q;

endmodule
